FILE: src/ipd_pkg.sv
// ============================================================================
// IR pulse distance decoder package
// Shared types, register codes, reset values and helper functions.
// ============================================================================
`default_nettype none

package ipd_pkg;

  // Event codes carried by the opcode field of an input beat.
  typedef enum logic [1:0] {
    OP_LEAD    = 2'd0,
    OP_DATA    = 2'd1,
    OP_TIMEOUT = 2'd2
  } ipd_op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LEAD_LOW  = 3'd0,
    REG_LEAD_HIGH = 3'd1,
    REG_GAP_LOW   = 3'd2,
    REG_GAP_HIGH  = 3'd3,
    REG_ZERO_LOW  = 3'd4,
    REG_ZERO_HIGH = 3'd5,
    REG_ONE_LOW   = 3'd6,
    REG_ONE_HIGH  = 3'd7
  } ipd_reg_e;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Reset values of the timing windows, in timer ticks.
  localparam logic [CFG_W-1:0] LEAD_LOW_RST  = 16'd8950;
  localparam logic [CFG_W-1:0] LEAD_HIGH_RST = 16'd9050;
  localparam logic [CFG_W-1:0] GAP_LOW_RST   = 16'd4400;
  localparam logic [CFG_W-1:0] GAP_HIGH_RST  = 16'd4600;
  localparam logic [CFG_W-1:0] ZERO_LOW_RST  = 16'd1100;
  localparam logic [CFG_W-1:0] ZERO_HIGH_RST = 16'd1400;
  localparam logic [CFG_W-1:0] ONE_LOW_RST   = 16'd2200;
  localparam logic [CFG_W-1:0] ONE_HIGH_RST  = 16'd2300;

  // Frame counters.
  localparam logic [5:0] EDGE_MAX       = 6'd63;
  localparam logic [5:0] BITS_PER_FRAME = 6'd32;
  localparam logic [5:0] GAP_EDGE       = 6'd2;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef struct packed {
    logic [CFG_W-1:0] lead_low;
    logic [CFG_W-1:0] lead_high;
    logic [CFG_W-1:0] gap_low;
    logic [CFG_W-1:0] gap_high;
    logic [CFG_W-1:0] zero_low;
    logic [CFG_W-1:0] zero_high;
    logic [CFG_W-1:0] one_low;
    logic [CFG_W-1:0] one_high;
  } ipd_cfg_t;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] address_check;
    logic [7:0] command_byte;
    logic [7:0] command_check;
  } ipd_result_t;

  // Reverse the bit order of a byte with three swap stages.
  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] x;
    x = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
    x = ((x & 8'hCC) >> 2) | ((x & 8'h33) << 2);
    x = ((x & 8'hAA) >> 1) | ((x & 8'h55) << 1);
    return x;
  endfunction

  // Strict window test: both bounds are exclusive.
  function automatic logic in_window(input logic [CFG_W-1:0] v,
                                     input logic [CFG_W-1:0] lo,
                                     input logic [CFG_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

endpackage

`default_nettype wire

FILE: src/ipd_cfg_regs.sv
// ============================================================================
// IR decoder timing registers
// Holds the eight timing window bounds, written through a plain write port.
// ============================================================================
`default_nettype none

module ipd_cfg_regs
  import ipd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output ipd_cfg_t                  cfg_o
);

  ipd_cfg_t cfg_q;

  // Register file with one write per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead_low  <= LEAD_LOW_RST;
      cfg_q.lead_high <= LEAD_HIGH_RST;
      cfg_q.gap_low   <= GAP_LOW_RST;
      cfg_q.gap_high  <= GAP_HIGH_RST;
      cfg_q.zero_low  <= ZERO_LOW_RST;
      cfg_q.zero_high <= ZERO_HIGH_RST;
      cfg_q.one_low   <= ONE_LOW_RST;
      cfg_q.one_high  <= ONE_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (ipd_reg_e'(cfg_idx_i))
        REG_LEAD_LOW:  cfg_q.lead_low  <= cfg_wdata_i;
        REG_LEAD_HIGH: cfg_q.lead_high <= cfg_wdata_i;
        REG_GAP_LOW:   cfg_q.gap_low   <= cfg_wdata_i;
        REG_GAP_HIGH:  cfg_q.gap_high  <= cfg_wdata_i;
        REG_ZERO_LOW:  cfg_q.zero_low  <= cfg_wdata_i;
        REG_ZERO_HIGH: cfg_q.zero_high <= cfg_wdata_i;
        REG_ONE_LOW:   cfg_q.one_low   <= cfg_wdata_i;
        REG_ONE_HIGH:  cfg_q.one_high  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/ipd_frame_core.sv
// ============================================================================
// IR decoder frame core
// Per-frame state machine logic: lead and gap checks, bit classification,
// byte shifting and result generation on a frame timeout.
// ============================================================================
`default_nettype none

module ipd_frame_core
  import ipd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ipd_cfg_t         cfg_i,
  input  wire logic             valid_i,
  input  wire logic [1:0]       opcode_i,
  input  wire logic [CFG_W-1:0] interval_i,
  output logic                  push_o,
  output ipd_result_t           result_o
);

  logic [5:0]      edge_count_q, edge_count_d;
  logic [5:0]      bit_count_q, bit_count_d;
  logic            lead_ok_q, lead_ok_d;
  logic            gap_ok_q, gap_ok_d;
  logic            lead_taken_q, lead_taken_d;
  logic [3:0][7:0] shift_q, shift_d;

  logic [5:0] edge_inc;
  logic [1:0] slot;
  logic       is_zero;
  logic       is_one;

  // Shared terms: saturating edge count, target byte and bit class.
  assign edge_inc = (edge_count_q < EDGE_MAX) ? edge_count_q + 6'd1 : edge_count_q;
  assign slot     = bit_count_q[4:3];
  assign is_zero  = in_window(interval_i, cfg_i.zero_low, cfg_i.zero_high);
  assign is_one   = in_window(interval_i, cfg_i.one_low, cfg_i.one_high);

  // Next-state logic for one event beat.
  always_comb begin
    edge_count_d = edge_count_q;
    bit_count_d  = bit_count_q;
    lead_ok_d    = lead_ok_q;
    gap_ok_d     = gap_ok_q;
    lead_taken_d = lead_taken_q;
    shift_d      = shift_q;
    push_o       = 1'b0;

    if (valid_i) begin
      unique case (ipd_op_e'(opcode_i))
        OP_LEAD: begin
          // Only the first lead edge of a frame counts.
          if (!lead_taken_q) begin
            edge_count_d = edge_inc;
            if (in_window(interval_i, cfg_i.lead_low, cfg_i.lead_high)) begin
              lead_ok_d = 1'b1;
            end
            lead_taken_d = 1'b1;
          end
        end
        OP_DATA: begin
          // A data edge before any counted edge only starts timing.
          if (edge_count_q != 6'd0) begin
            edge_count_d = edge_inc;
            if (edge_inc == GAP_EDGE &&
                in_window(interval_i, cfg_i.gap_low, cfg_i.gap_high)) begin
              gap_ok_d = 1'b1;
            end
            if (lead_ok_q && gap_ok_q && edge_inc > GAP_EDGE &&
                bit_count_q < BITS_PER_FRAME) begin
              // An unclassified interval still consumes its bit slot.
              if (is_zero) begin
                shift_d[slot] = {shift_q[slot][6:0], 1'b0};
              end else if (is_one) begin
                shift_d[slot] = {shift_q[slot][6:0], 1'b1};
              end
              bit_count_d = bit_count_q + 6'd1;
            end
          end
        end
        OP_TIMEOUT: begin
          // A valid frame is emitted LSB first; the per-frame counters and flags always clear.
          if (lead_ok_q && gap_ok_q) begin
            shift_d[0] = flip8(shift_q[0]);
            shift_d[1] = flip8(shift_q[1]);
            shift_d[2] = flip8(shift_q[2]);
            shift_d[3] = flip8(shift_q[3]);
            push_o     = 1'b1;
          end
          edge_count_d = 6'd0;
          bit_count_d  = 6'd0;
          lead_ok_d    = 1'b0;
          gap_ok_d     = 1'b0;
          lead_taken_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign result_o.address_byte  = shift_d[0];
  assign result_o.address_check = shift_d[1];
  assign result_o.command_byte  = shift_d[2];
  assign result_o.command_check = shift_d[3];

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= 6'd0;
      bit_count_q  <= 6'd0;
      lead_ok_q    <= 1'b0;
      gap_ok_q     <= 1'b0;
      lead_taken_q <= 1'b0;
      shift_q      <= '0;
    end else begin
      edge_count_q <= edge_count_d;
      bit_count_q  <= bit_count_d;
      lead_ok_q    <= lead_ok_d;
      gap_ok_q     <= gap_ok_d;
      lead_taken_q <= lead_taken_d;
      shift_q      <= shift_d;
    end
  end

  // The bit counter never runs past one frame.
  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_count_q <= BITS_PER_FRAME)
    else $error("bit counter exceeded frame length");

  // Bits are only collected after both the lead and the gap passed.
  a_bits_need_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_count_q != 6'd0) |-> (lead_ok_q && gap_ok_q))
    else $error("bits collected without a valid lead and gap");

  // A passed lead check implies the lead edge was taken.
  a_lead_ok_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lead_ok_q |-> lead_taken_q)
    else $error("lead flagged ok without a lead edge");

  // Emitting a frame leaves the per-frame counters cleared.
  a_push_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (edge_count_q == 6'd0 && bit_count_q == 6'd0 && !lead_taken_q))
    else $error("frame state not cleared after a result");

endmodule

`default_nettype wire

FILE: src/ipd_out_fifo.sv
// ============================================================================
// IR decoder result queue
// Small register queue that holds decoded frames until the sink takes them.
// ============================================================================
`default_nettype none

module ipd_out_fifo
  import ipd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire ipd_result_t           push_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output ipd_result_t                out_data_o,
  output logic [FIFO_CNT_W-1:0]      count_o
);

  ipd_result_t                 entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]       count_q;
  logic                        pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = entry_q[rd_ptr_q];
  assign count_o     = count_q;

  // Pointer wrap at the queue depth.
  function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // The fill count stays within the queue depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  // The input throttle must prevent a push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |-> (count_q != FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // A lone push grows the queue by exactly one beat.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("result queue count did not advance on push");

endmodule

`default_nettype wire

FILE: src/ir_pulse_distance_decoder.sv
// ============================================================================
// IR pulse distance decoder
// Decodes pulse-distance remote frames from timed edge events.
// ============================================================================
// The block takes one event beat per cycle unless stalled. Each accepted event
// is held in an input register, where the frame logic updates its state; the
// frame-timeout beat that ends a valid frame writes a decoded frame of four
// bytes into a three-entry result queue, where it waits for the sink. The input
// stalls only when that queue and the event in the input register could fill
// up, which happens when the sink holds off results. The user must write timing
// windows through the configuration port only while idle; the block does not enforce it.
`default_nettype none

module ir_pulse_distance_decoder
  import ipd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  // Event input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [CFG_W-1:0]     interval_i,
  // Frame output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                address_byte_o,
  output logic [7:0]                address_check_o,
  output logic [7:0]                command_byte_o,
  output logic [7:0]                command_check_o
);

  ipd_cfg_t                cfg;
  logic                    in_valid_q;
  logic [1:0]              opcode_q;
  logic [CFG_W-1:0]        interval_q;
  logic                    in_accept;
  logic                    push;
  ipd_result_t             push_data;
  ipd_result_t             out_data;
  logic [FIFO_CNT_W-1:0]   fifo_count;
  logic [FIFO_CNT_W:0]     pending;

  // Throttle input so that every beat in flight has a queue slot.
  assign pending    = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, in_valid_q};
  assign in_stall_o = (pending >= (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q   <= opcode_i;
      interval_q <= interval_i;
    end
  end

  // Timing window registers.
  ipd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Frame decoding logic.
  ipd_frame_core u_frame_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (in_valid_q),
    .opcode_i   (opcode_q),
    .interval_i (interval_q),
    .push_o     (push),
    .result_o   (push_data)
  );

  // Result queue toward the sink.
  ipd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data),
    .count_o     (fifo_count)
  );

  assign address_byte_o  = out_data.address_byte;
  assign address_check_o = out_data.address_check;
  assign command_byte_o  = out_data.command_byte;
  assign command_check_o = out_data.command_check;

endmodule

`default_nettype wire
